// ----- design/ced_pkg.sv -----
// Package for the effective cloud fraction block: item types, codes and constants.
// Used by the top level, the checker and the testbench; no dependencies.
package ced_pkg;

  localparam int COEFF_LEVELS_DEF  = 64;
  localparam int HUMIDITY_BINS_DEF = 32;
  localparam int BIN_W     = 5;
  localparam int OUT_W     = 19;
  localparam int CFG_IDX_W = 2;
  localparam int FRAC_W    = 16;
  localparam int PROD_W    = 32;
  localparam int NUM_W     = 31;
  localparam int DVD_W     = 50;

  localparam logic [15:0]      RH_HUNDRED    = 16'd25600;
  localparam logic [15:0]      BIN_WIDTH_RST = 16'd1280;
  localparam logic [15:0]      TOL_RST       = 16'd1;
  localparam logic [OUT_W-1:0] HALF_Q15      = OUT_W'(16384);

  typedef enum logic {
    OP_LOAD    = 1'b0,
    OP_COMPUTE = 1'b1
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BIN_WIDTH = 2'd0,
    REG_TOLERANCE = 2'd1
  } reg_idx_e;

  typedef struct packed {
    op_e         op;
    logic [7:0]  level;
    logic [4:0]  coeff_bin;
    logic        table_select;
    logic [15:0] coefficient;
    logic [15:0] rel_humidity;
    logic [15:0] liquid_fraction;
    logic [15:0] ice_fraction;
  } in_item_t;

  typedef struct packed {
    logic [OUT_W-1:0] liquid_effective;
    logic [OUT_W-1:0] ice_effective;
  } out_item_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] reg_index;
    logic [15:0]          wdata;
  } cfg_item_t;

  typedef struct packed {
    op_e              op;
    logic [7:0]       level;
    logic [4:0]       coeff_bin;
    logic             table_select;
    logic [15:0]      coefficient;
    logic             hi_rh;
    logic [FRAC_W-1:0] lf;
    logic [FRAC_W-1:0] fi;
    logic [PROD_W-1:0] prod;
  } ctl_t;

  typedef struct packed {
    logic zero;
    logic small_den;
    logic pos_l;
    logic pos_i;
  } flag_t;

endpackage

// ----- design/ced_stream_if.sv -----
// Valid/ready channel carrying one payload of type T.
// Instantiated with the item types of ced_pkg.
interface ced_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- design/cloud_effective_fraction.sv -----
// Top level of the effective cloud fraction block.
// Depends on ced_pkg, ced_stream_if, ced_ram and ced_div.
//
// Channels: in_i takes load and compute items, out_o returns one result per
// compute item, cfg_i writes bin_width (index 0) and tolerance (index 1).
// A load writes one coefficient into the liquid or ice table; loads outside
// the table are dropped and give no result. A compute item returns both
// effective fractions in Q4.15, saturating.
// Throughput: one item per cycle while out_o is not stalled. The humidity bin comes
// from a 6-stage bin divider, the table read is registered in the coefficient RAMs,
// and each fraction goes through a 20-stage quotient pipeline.
// Reset clears all valid flags and loads bin_width 1280 and tolerance 1;
// table contents stay undefined until loaded.
// When out_o stalls, the whole pipeline holds and in_i.ready drops in the
// same cycle; it rises again as soon as the held result is transferred.
// cfg_i is always ready; write it only while no item is in flight.
module cloud_effective_fraction #(
  parameter int COEFF_LEVELS  = ced_pkg::COEFF_LEVELS_DEF,
  parameter int HUMIDITY_BINS = ced_pkg::HUMIDITY_BINS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ced_stream_if.sink  in_i,
  ced_stream_if.source out_o,
  ced_stream_if.sink  cfg_i
);
  import ced_pkg::*;

  localparam int DEPTH = COEFF_LEVELS * HUMIDITY_BINS;
  localparam int AW    = $clog2(DEPTH);
  localparam int BL    = BIN_W + 1;
  localparam int QL    = OUT_W + 1;

  logic        adv;
  logic [15:0] bw_q, tol_q;

  logic        va_q;
  ctl_t        a_q;
  ctl_t        a_d;
  logic [15:0] a_rh_q;

  ctl_t        dl_q [BL];
  logic [BL-1:0] vdl_q;
  logic [BIN_W-1:0] bin_quo;

  ctl_t        r;
  logic        rv, lvl_ok, bin_ok, we_l, we_i;
  logic [BIN_W-1:0] bin_c, abin;
  logic [AW-1:0] addr;
  logic signed [32:0] den_s, numl_s, numi_s, tol_s;
  logic [15:0] ram_l, ram_i;

  logic              vb_q;
  flag_t             b_f_q;
  logic [NUM_W-1:0]  b_nl_q, b_ni_q, b_den_q;

  logic              vc_q;
  flag_t             c_f_q;
  logic [DVD_W-1:0]  c_dl_q, c_di_q;
  logic [NUM_W-1:0]  c_den_q;

  flag_t             f_q [QL];
  logic [QL-1:0]     vf_q;
  logic [OUT_W-1:0]  q_l, q_i;

  logic              out_valid_q;
  out_item_t         out_q, out_d;

  assign adv         = !out_valid_q || out_o.ready;
  assign in_i.ready  = adv;
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bw_q  <= BIN_WIDTH_RST;
      tol_q <= TOL_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.data.reg_index)
        REG_BIN_WIDTH: bw_q  <= cfg_i.data.wdata;
        REG_TOLERANCE: tol_q <= cfg_i.data.wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    a_d.op           = in_i.data.op;
    a_d.level        = in_i.data.level;
    a_d.coeff_bin    = in_i.data.coeff_bin;
    a_d.table_select = in_i.data.table_select;
    a_d.coefficient  = in_i.data.coefficient;
    a_d.hi_rh        = in_i.data.rel_humidity > RH_HUNDRED;
    a_d.lf           = in_i.data.liquid_fraction;
    a_d.fi           = in_i.data.ice_fraction;
    a_d.prod         = PROD_W'(in_i.data.liquid_fraction) * PROD_W'(in_i.data.ice_fraction);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q  <= 1'b0;
      vdl_q <= '0;
      vb_q  <= 1'b0;
      vc_q  <= 1'b0;
      vf_q  <= '0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      va_q  <= in_i.valid;
      vdl_q <= {vdl_q[BL-2:0], va_q};
      vb_q  <= rv && (r.op == OP_COMPUTE);
      vc_q  <= vb_q;
      vf_q  <= {vf_q[QL-2:0], vc_q};
      out_valid_q <= vf_q[QL-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_q    <= a_d;
      a_rh_q <= in_i.data.rel_humidity;
      dl_q[0] <= a_q;
      for (int i = 1; i < BL; i++) begin
        dl_q[i] <= dl_q[i-1];
      end
    end
  end

  ced_div #(.NW(16), .DW(16), .QW(BIN_W)) u_bin_div (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (a_rh_q),
    .den_i (bw_q),
    .quo_o (bin_quo)
  );

  assign r  = dl_q[BL-1];
  assign rv = vdl_q[BL-1];

  always_comb begin
    priority if (r.hi_rh || bin_quo > BIN_W'(HUMIDITY_BINS - 1)) begin
      bin_c = BIN_W'(HUMIDITY_BINS - 1);
    end else begin
      bin_c = bin_quo;
    end
    abin   = (r.op == OP_LOAD) ? r.coeff_bin : bin_c;
    lvl_ok = {1'b0, r.level} < 9'(COEFF_LEVELS);
    bin_ok = {1'b0, r.coeff_bin} < 6'(HUMIDITY_BINS);
    addr   = AW'(int'(r.level) * HUMIDITY_BINS + int'(abin));
    we_l   = adv && rv && (r.op == OP_LOAD) && lvl_ok && bin_ok && !r.table_select;
    we_i   = adv && rv && (r.op == OP_LOAD) && lvl_ok && bin_ok && r.table_select;
    den_s  = 33'sh040000000 - $signed({1'b0, r.prod});
    numl_s = $signed({2'b00, r.lf, 15'b0}) - $signed({1'b0, r.prod});
    numi_s = $signed({2'b00, r.fi, 15'b0}) - $signed({1'b0, r.prod});
    tol_s  = $signed({2'b00, tol_q, 15'b0});
  end

  ced_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_liquid_ram (
    .clk_i   (clk_i),
    .we_i    (we_l),
    .waddr_i (addr),
    .wdata_i (r.coefficient),
    .re_i    (adv),
    .raddr_i (addr),
    .rdata_o (ram_l)
  );

  ced_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_ice_ram (
    .clk_i   (clk_i),
    .we_i    (we_i),
    .waddr_i (addr),
    .wdata_i (r.coefficient),
    .re_i    (adv),
    .raddr_i (addr),
    .rdata_o (ram_i)
  );

  always_ff @(posedge clk_i) begin
    if (adv) begin
      b_f_q.zero      <= !lvl_ok;
      b_f_q.small_den <= den_s <= tol_s;
      b_f_q.pos_l     <= numl_s > 33'sd0;
      b_f_q.pos_i     <= numi_s > 33'sd0;
      b_nl_q  <= numl_s[NUM_W-1:0];
      b_ni_q  <= numi_s[NUM_W-1:0];
      b_den_q <= den_s[NUM_W-1:0];

      c_f_q   <= b_f_q;
      c_dl_q  <= {(47'(ram_l) * 47'(b_nl_q)), 3'b000};
      c_di_q  <= {(47'(ram_i) * 47'(b_ni_q)), 3'b000};
      c_den_q <= b_den_q;

      f_q[0] <= c_f_q;
      for (int i = 1; i < QL; i++) begin
        f_q[i] <= f_q[i-1];
      end
    end
  end

  ced_div #(.NW(DVD_W), .DW(NUM_W), .QW(OUT_W)) u_liquid_div (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (c_dl_q),
    .den_i (c_den_q),
    .quo_o (q_l)
  );

  ced_div #(.NW(DVD_W), .DW(NUM_W), .QW(OUT_W)) u_ice_div (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (c_di_q),
    .den_i (c_den_q),
    .quo_o (q_i)
  );

  always_comb begin
    priority if (f_q[QL-1].zero) begin
      out_d.liquid_effective = '0;
      out_d.ice_effective    = '0;
    end else if (f_q[QL-1].small_den) begin
      out_d.liquid_effective = HALF_Q15;
      out_d.ice_effective    = HALF_Q15;
    end else begin
      out_d.liquid_effective = f_q[QL-1].pos_l ? q_l : '0;
      out_d.ice_effective    = f_q[QL-1].pos_i ? q_i : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= out_d;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;
endmodule

// ----- design/ced_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module ced_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

// ----- design/ced_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, saturating to all ones.
// The pipeline advances only while en_i is high; no dependencies.
module ced_div #(
  parameter int NW = 50,
  parameter int DW = 31,
  parameter int QW = 19
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic [QW-1:0] quo_o
);
  localparam int WW = (NW > DW + QW) ? NW : DW + QW;

  logic [WW-1:0] rem_q [QW+1];
  logic [DW-1:0] den_q [QW+1];
  logic [QW-1:0] quo_q [QW+1];
  logic          sat_q [QW+1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= WW'(num_i);
      den_q[0] <= den_i;
      quo_q[0] <= '0;
      sat_q[0] <= WW'(num_i) >= (WW'(den_i) << QW);
    end
  end

  for (genvar g = 1; g <= QW; g++) begin : g_stage
    logic [WW-1:0] trial;
    logic          take;
    assign trial = WW'(den_q[g-1]) << (QW - g);
    assign take  = rem_q[g-1] >= trial;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[g] <= take ? rem_q[g-1] - trial : rem_q[g-1];
        den_q[g] <= den_q[g-1];
        quo_q[g] <= {quo_q[g-1][QW-2:0], take};
        sat_q[g] <= sat_q[g-1];
      end
    end
  end

  assign quo_o = sat_q[QW] ? '1 : quo_q[QW];
endmodule

// ----- design/ced_chk.sv -----
// Port-level checks for cloud_effective_fraction, attached by bind.
// Depends on ced_pkg for the output width.
module ced_chk (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [ced_pkg::OUT_W-1:0] liquid_effective,
  input logic [ced_pkg::OUT_W-1:0] ice_effective
);
  import ced_pkg::*;

  a_reset_clears: assert property (@(posedge clk_i) !rst_ni |=> !out_valid)
    else $error("result valid right after reset");

  a_stall_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input blocked without an output stall");

  a_resume: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && out_ready) |=> in_ready || out_valid)
    else $error("input still blocked after output transfer");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(liquid_effective) && $stable(ice_effective)))
    else $error("stalled result changed");
endmodule

bind cloud_effective_fraction ced_chk u_ced_chk (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_ready         (in_i.ready),
  .out_valid        (out_o.valid),
  .out_ready        (out_o.ready),
  .liquid_effective (out_o.data.liquid_effective),
  .ice_effective    (out_o.data.ice_effective)
);

// ----- tb/tb_cloud_effective_fraction.sv -----
// Testbench for cloud_effective_fraction: loads coefficient tables, streams compute items
// and checks each result against an in-bench predictor of the effective fractions.
// Depends on ced_pkg, ced_stream_if and the design files.
module tb_cloud_effective_fraction;
  import ced_pkg::*;

  localparam int LEVELS      = COEFF_LEVELS_DEF;
  localparam int BINS        = HUMIDITY_BINS_DEF;
  localparam int FILL_LEVELS = 6;
  localparam int SETTLE      = 40;

  logic clk_i;
  logic rst_ni;

  ced_stream_if #(.T(in_item_t))  in_ch  ();
  ced_stream_if #(.T(out_item_t)) out_ch ();
  ced_stream_if #(.T(cfg_item_t)) cfg_ch ();

  cloud_effective_fraction dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch.sink),
    .out_o (out_ch.source),
    .cfg_i (cfg_ch.sink)
  );

  logic [15:0] liq_tbl [LEVELS*BINS];
  logic [15:0] ice_tbl [LEVELS*BINS];
  logic [15:0] bin_width_q;
  logic [15:0] tolerance_q;
  out_item_t   expected_fracs [$];
  bit          failed;
  bit          idle_on;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #40_000_000;
    $display("FAIL cloud_effective_fraction");
    $finish;
  end

  function automatic logic [OUT_W-1:0] eff_frac(logic [15:0] coeff, longint num, longint den);
    longint q;
    if (num <= 0) return '0;
    q = (longint'(coeff) * num * 8) / den;
    return (q > 524287) ? OUT_W'(524287) : OUT_W'(q);
  endfunction

  function automatic int bin_of(logic [15:0] rh);
    int b;
    if (rh > RH_HUNDRED || bin_width_q == 0) b = BINS - 1;
    else b = int'(rh) / int'(bin_width_q);
    if (b > BINS - 1) b = BINS - 1;
    return b;
  endfunction

  function automatic void predict_fracs(in_item_t it);
    out_item_t r;
    longint prod, den;
    int idx;
    r = '0;
    if (it.op == OP_LOAD) begin
      if (it.level < LEVELS) begin
        idx = it.level * BINS + it.coeff_bin;
        if (it.table_select) ice_tbl[idx] = it.coefficient;
        else liq_tbl[idx] = it.coefficient;
      end
      return;
    end
    if (it.level < LEVELS) begin
      idx = it.level * BINS + bin_of(it.rel_humidity);
      prod = longint'(it.liquid_fraction) * longint'(it.ice_fraction);
      den = (longint'(1) << 30) - prod;
      if (den <= longint'(tolerance_q) * 32768) begin
        r.liquid_effective = HALF_Q15;
        r.ice_effective = HALF_Q15;
      end else begin
        r.liquid_effective = eff_frac(liq_tbl[idx], longint'(it.liquid_fraction) * 32768 - prod, den);
        r.ice_effective = eff_frac(ice_tbl[idx], longint'(it.ice_fraction) * 32768 - prod, den);
      end
    end
    expected_fracs.push_back(r);
  endfunction

  task automatic idle_burst();
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
  endtask

  task automatic send_item(in_item_t it);
    idle_burst();
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    do @(posedge clk_i); while (!in_ch.ready);
    predict_fracs(it);
  endtask

  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (expected_fracs.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_ch.data);
        failed = 1'b1;
      end else begin
        want = expected_fracs.pop_front();
        if (out_ch.data.liquid_effective !== want.liquid_effective) begin
          $display("%0t: liquid_effective expected %0d actual %0d", $time,
                   want.liquid_effective, out_ch.data.liquid_effective);
          failed = 1'b1;
        end
        if (out_ch.data.ice_effective !== want.ice_effective) begin
          $display("%0t: ice_effective expected %0d actual %0d", $time,
                   want.ice_effective, out_ch.data.ice_effective);
          failed = 1'b1;
        end
      end
    end
  end

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (idle_on && $urandom_range(0, 7) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
    end
  end

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (expected_fracs.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [15:0] val);
    drain();
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= '{reg_index: idx, wdata: val};
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    if (idx == REG_BIN_WIDTH) bin_width_q = val;
    else tolerance_q = val;
  endtask

  function automatic int pick_level();
    int l;
    l = $urandom_range(0, FILL_LEVELS - 1);
    return (l == FILL_LEVELS - 1) ? LEVELS - 1 : l;
  endfunction

  function automatic in_item_t load_item(int lvl, int b, bit sel, logic [15:0] c);
    in_item_t it;
    it = in_item_t'($urandom());
    it.op = OP_LOAD;
    it.level = 8'(lvl);
    it.coeff_bin = 5'(b);
    it.table_select = sel;
    it.coefficient = c;
    it.rel_humidity = 16'($urandom());
    it.liquid_fraction = 16'($urandom());
    it.ice_fraction = 16'($urandom());
    return it;
  endfunction

  function automatic in_item_t compute_item(int lvl, logic [15:0] rh, logic [15:0] lf,
                                            logic [15:0] fi);
    in_item_t it;
    it.op = OP_COMPUTE;
    it.level = 8'(lvl);
    it.coeff_bin = 5'($urandom());
    it.table_select = 1'($urandom());
    it.coefficient = 16'($urandom());
    it.rel_humidity = rh;
    it.liquid_fraction = lf;
    it.ice_fraction = fi;
    return it;
  endfunction

  function automatic logic [15:0] rand_frac();
    case ($urandom_range(0, 5))
      0: return 16'd0;
      1: return 16'd32768;
      2: return 16'($urandom_range(32760, 32768));
      3: return 16'($urandom());
      default: return 16'($urandom_range(0, 32768));
    endcase
  endfunction

  task automatic test_table_fill();
    int l;
    for (int k = 0; k < FILL_LEVELS; k++) begin
      l = (k == FILL_LEVELS - 1) ? LEVELS - 1 : k;
      for (int b = 0; b < BINS; b++) begin
        send_item(load_item(l, b, 1'b0, 16'($urandom())));
        send_item(load_item(l, b, 1'b1, 16'($urandom())));
      end
    end
  endtask

  task automatic test_directed();
    send_item(load_item(0, 0, 1'b0, 16'hFFFF));
    send_item(load_item(0, 0, 1'b1, 16'h0000));
    send_item(load_item(63, 31, 1'b0, 16'h1000));
    send_item(load_item(255, 31, 1'b1, 16'hFFFF));
    send_item(load_item(64, 0, 1'b0, 16'h1234));
    send_item(compute_item(0, 16'd0, 16'd32768, 16'd0));
    send_item(compute_item(0, 16'd0, 16'd0, 16'd0));
    send_item(compute_item(0, 16'd0, 16'd32768, 16'd32768));
    send_item(compute_item(0, 16'd0, 16'd32767, 16'd32767));
    send_item(compute_item(63, 16'd25600, 16'd16384, 16'd16384));
    send_item(compute_item(63, 16'd25601, 16'd100, 16'd200));
    send_item(compute_item(63, 16'hFFFF, 16'hFFFF, 16'd0));
    send_item(compute_item(3, 16'd12345, 16'hFFFF, 16'hFFFF));
    send_item(compute_item(64, 16'd100, 16'd1000, 16'd2000));
    send_item(compute_item(255, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_item(compute_item(4, 16'd25599, 16'd1, 16'd32768));
  endtask

  task automatic test_random(int n);
    in_item_t it;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 9) == 0)
        it = load_item($urandom_range(0, 255), $urandom_range(0, 31), 1'($urandom()),
                       16'($urandom()));
      else
        it = compute_item(($urandom_range(0, 9) == 0) ? $urandom_range(LEVELS, 255)
                                                       : pick_level(),
                          ($urandom_range(0, 3) == 0) ? 16'($urandom())
                                                      : 16'($urandom_range(0, 25700)),
                          rand_frac(), rand_frac());
      send_item(it);
    end
  endtask

  task automatic test_config_sweep();
    write_reg(REG_BIN_WIDTH, 16'd1);
    write_reg(REG_TOLERANCE, 16'd0);
    test_random(100);
    write_reg(REG_BIN_WIDTH, 16'd65535);
    write_reg(REG_TOLERANCE, 16'd32768);
    test_random(100);
    write_reg(REG_BIN_WIDTH, 16'd0);
    write_reg(REG_TOLERANCE, 16'd100);
    test_random(100);
    write_reg(REG_BIN_WIDTH, 16'd800);
    write_reg(REG_TOLERANCE, 16'd1);
    test_random(100);
  endtask

  initial begin
    failed = 1'b0;
    idle_on = 1'b1;
    bin_width_q = BIN_WIDTH_RST;
    tolerance_q = TOL_RST;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    idle_on = 1'b0;
    test_table_fill();
    idle_on = 1'b1;
    test_directed();
    test_random(250);
    test_config_sweep();
    idle_on = 1'b0;
    test_random(250);
    drain();
    if (!failed) begin
      $display("PASS cloud_effective_fraction");
    end else begin
      $display("FAIL cloud_effective_fraction");
    end
    $finish;
  end
endmodule
